// File: hdl/uqpe_pkg.sv
// Types, character constants and byte classification for the query percent encoder.
// No dependencies; used by every other file of the block except uqpe_if.
package uqpe_pkg;

  localparam int unsigned LEN_W = 16;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DIGIT0  = 8'h30;
  localparam logic [7:0] CH_HEX_A10 = 8'h37;  // 'A' - 10
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd1023;

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_HEX,
    KIND_OVF
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  function automatic logic passes_plain(input logic [7:0] c);
    logic alnum;
    logic mark;
    alnum = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
            (c >= 8'h30 && c <= 8'h39);
    case (c)
      8'h2D, 8'h2E, 8'h5F, 8'h7E,
      8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29,
      8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D,
      8'h3A, 8'h40, 8'h2F, 8'h3F: mark = 1'b1;
      default: mark = 1'b0;
    endcase
    return alnum || mark;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] ext;
    ext = {4'h0, v};
    return (v < 4'd10) ? (CH_DIGIT0 + ext) : (CH_HEX_A10 + ext);
  endfunction

endpackage

// File: hdl/uqpe_if.sv
// Channel interfaces of the query percent encoder: input bytes, output characters,
// and the configuration write channel. Depends on nothing.
interface uqpe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface uqpe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;
  logic       status;
  modport source (output valid, output out_char, output out_last, output status,
                  input ready);
  modport sink   (input valid, input out_char, input out_last, input status,
                  output ready);
endinterface

interface uqpe_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/uqpe_front.sv
// Front end: accepts input bytes, classifies them, tracks encoded length and
// overflow, and pushes commands to the queue. Depends on uqpe_pkg and uqpe_if.
module uqpe_front (
  input  logic                   clk,
  input  logic                   rst,
  uqpe_in_if.sink                in_ch,
  uqpe_cfg_if.sink               cfg,
  output logic                   push_valid,
  input  logic                   push_ready,
  output uqpe_pkg::cmd_t         push_data
);

  logic [uqpe_pkg::LEN_W-1:0] max_len;
  logic [uqpe_pkg::LEN_W-1:0] out_count;
  logic                       discarding;
  logic                       accept;
  logic                       plain;
  logic [1:0]                 need;
  logic [uqpe_pkg::LEN_W:0]   sum;
  logic                       ovf;

  assign cfg.ready   = 1'b1;
  assign in_ch.ready = push_ready || discarding;
  assign accept      = in_ch.valid && in_ch.ready;

  assign plain = uqpe_pkg::passes_plain(in_ch.in_byte);
  assign need  = plain ? 2'd1 : 2'd3;
  assign sum   = {1'b0, out_count} + {{(uqpe_pkg::LEN_W-1){1'b0}}, need};
  assign ovf   = sum > {1'b0, max_len};

  assign push_valid = in_ch.valid && !discarding;
  always_comb begin
    push_data.data = in_ch.in_byte;
    push_data.last = in_ch.in_last;
    if (ovf) begin
      push_data.kind = uqpe_pkg::KIND_OVF;
    end else if (plain) begin
      push_data.kind = uqpe_pkg::KIND_PLAIN;
    end else begin
      push_data.kind = uqpe_pkg::KIND_HEX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len    <= uqpe_pkg::MAX_LEN_RESET;
      out_count  <= '0;
      discarding <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        max_len <= cfg.data;
      end
      if (accept) begin
        if (discarding) begin
          if (in_ch.in_last) begin
            discarding <= 1'b0;
            out_count  <= '0;
          end
        end else if (ovf) begin
          out_count  <= '0;
          discarding <= !in_ch.in_last;
        end else begin
          out_count <= in_ch.in_last ? '0 : sum[uqpe_pkg::LEN_W-1:0];
        end
      end
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    out_count <= max_len || $past(cfg.valid))
    else $error("encoded length passed max_len");

endmodule

// File: hdl/uqpe_queue.sv
// Short command queue between front and back ends.
// Depends on uqpe_pkg.
module uqpe_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  uqpe_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output uqpe_pkg::cmd_t pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  uqpe_pkg::cmd_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = count != CNT_FULL;
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue count out of range");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count lost a transfer");

endmodule

// File: hdl/uqpe_back.sv
// Back end: expands queued commands into output characters, one per cycle while
// out_ch is ready, through an output register. Depends on uqpe_pkg and uqpe_if.
module uqpe_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  uqpe_pkg::cmd_t pop_data,
  uqpe_out_if.source     out_ch
);

  uqpe_pkg::cmd_t cur;
  logic           cur_valid;
  logic [1:0]     phase;
  logic           ov;
  logic [7:0]     ov_char;
  logic           ov_last;
  logic           ov_status;
  logic           can_load;
  logic           fire;
  logic           final_ch;
  logic [7:0]     char_next;
  logic           last_next;
  logic           status_next;

  assign can_load  = !ov || out_ch.ready;
  assign fire      = cur_valid && can_load;
  assign pop_ready = !cur_valid || (fire && final_ch);

  always_comb begin
    final_ch    = 1'b1;
    char_next   = cur.data;
    last_next   = cur.last;
    status_next = 1'b0;
    case (cur.kind)
      uqpe_pkg::KIND_PLAIN: begin
        char_next = cur.data;
      end
      uqpe_pkg::KIND_HEX: begin
        final_ch = phase == 2'd2;
        last_next = cur.last && final_ch;
        if (phase == 2'd0) begin
          char_next = uqpe_pkg::CH_PERCENT;
        end else if (phase == 2'd1) begin
          char_next = uqpe_pkg::hex_digit(cur.data[7:4]);
        end else begin
          char_next = uqpe_pkg::hex_digit(cur.data[3:0]);
        end
      end
      uqpe_pkg::KIND_OVF: begin
        char_next   = 8'h00;
        last_next   = 1'b1;
        status_next = 1'b1;
      end
      default: begin
        char_next = cur.data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= 2'd0;
      ov        <= 1'b0;
    end else begin
      if (pop_ready) begin
        cur_valid <= pop_valid;
        phase     <= 2'd0;
      end else if (fire) begin
        phase <= phase + 2'd1;
      end
      if (can_load) begin
        ov <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready) begin
      cur <= pop_data;
    end
    if (fire) begin
      ov_char   <= char_next;
      ov_last   <= last_next;
      ov_status <= status_next;
    end
  end

  assign out_ch.valid    = ov;
  assign out_ch.out_char = ov_char;
  assign out_ch.out_last = ov_last;
  assign out_ch.status   = ov_status;

  a_ovf_shape: assert property (@(posedge clk) disable iff (rst)
    (ov && ov_status) |-> (ov_char == 8'h00 && ov_last))
    else $error("overflow result malformed");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> phase != 2'd3)
    else $error("expansion phase out of range");

endmodule

// File: hdl/uri_query_percent_encoder.sv
// Top level of the query percent encoder: front end, command queue, back end.
// Depends on uqpe_pkg, uqpe_if, uqpe_front, uqpe_queue and uqpe_back.
//
// Bytes of a query string enter on in_ch, one per transfer, with in_last on the
// final byte; the encoded text leaves on out_ch one character per transfer. A byte
// in the unreserved or sub-delimiter sets, or one of : @ / ?, passes unchanged;
// any other byte becomes '%' and two uppercase hex digits. The output channel, one
// character per cycle while out_ch is ready, sets the sustained rate; the front end
// keeps taking bytes while the QUEUE_DEPTH-entry command queue has room, and bytes
// dropped after an overflow are taken without entering the queue. If a string's
// encoded length would pass max_len (written on cfg, reset 1023), one result with
// status 1, out_char 0 and out_last 1 is sent and the rest of the string is dropped.
// Write cfg only while the block is idle.
module uri_query_percent_encoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  uqpe_in_if.sink     in_ch,
  uqpe_out_if.source  out_ch,
  uqpe_cfg_if.sink    cfg
);

  logic           push_valid;
  logic           push_ready;
  uqpe_pkg::cmd_t push_data;
  logic           pop_valid;
  logic           pop_ready;
  uqpe_pkg::cmd_t pop_data;

  uqpe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  uqpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  uqpe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule
